[hdl/pvla_pkg.sv]
// ----------------------------------------------------------------------------
// pvla_pkg
// Shared constants for the projected vector line angle unit: parameter
// defaults, projection plane codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pvla_pkg;

  localparam int COMPONENT_BITS_DEF  = 24;
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STAGES_DEF   = 16;

  // arctangent table: degrees with TABLE_FRAC fraction bits
  localparam int TABLE_FRAC = 24;
  localparam int TABLE_LEN  = 24;

  // normalized magnitudes carry their leading one at this bit
  localparam int NORM_MSB = 30;

  localparam logic [1:0] PLANE_XZ = 2'd0;
  localparam logic [1:0] PLANE_XY = 2'd1;
  localparam logic [1:0] PLANE_YZ = 2'd2;

  // atan(2^-i) in degrees, scaled by 2^24
  localparam logic [31:0] ATAN_DEG [TABLE_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

endpackage

[hdl/projected_vector_line_angle_unit.sv]
// ----------------------------------------------------------------------------
// projected_vector_line_angle_unit
// Angle between the 2-D projections of two 3-D vectors, folded to 0..90 deg.
// ----------------------------------------------------------------------------
// One vector pair may enter every cycle while in_ready is high; the block is
// fully pipelined, with one register stage each for the products, the dot and
// cross magnitudes, the larger-magnitude pick, the leading-one search and the
// normalizing shift, one per CORDIC rotation, and one for rounding into the
// output register. A stall at the output backs up stage by stage, so empty
// stages still fill while the result waits. The plane register should only be
// written when the pipeline is empty. A zero projected vector gives 90 deg.
// line_angle is in units of 2^-ANGLE_FRAC_BITS degree.
module projected_vector_line_angle_unit #(
  parameter int COMPONENT_BITS  = pvla_pkg::COMPONENT_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = pvla_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = pvla_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_enable,
  input  logic [1:0]                         cfg_write_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COMPONENT_BITS-1:0]   first_x,
  input  logic signed [COMPONENT_BITS-1:0]   first_y,
  input  logic signed [COMPONENT_BITS-1:0]   first_z,
  input  logic signed [COMPONENT_BITS-1:0]   second_x,
  input  logic signed [COMPONENT_BITS-1:0]   second_y,
  input  logic signed [COMPONENT_BITS-1:0]   second_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [6+ANGLE_FRAC_BITS:0]         line_angle
);

  localparam int CB   = COMPONENT_BITS;
  localparam int PW   = 2 * CB;
  localparam int MW   = 2 * CB;
  localparam int POSW = $clog2(MW);
  localparam int NM   = pvla_pkg::NORM_MSB;
  localparam int EXW  = MW + NM;
  localparam int XW   = NM + 4;
  localparam int ZW   = 33;
  localparam int OW   = 7 + ANGLE_FRAC_BITS;
  localparam int SH   = pvla_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam int NST  = (CORDIC_STAGES < pvla_pkg::TABLE_LEN) ?
                        CORDIC_STAGES : pvla_pkg::TABLE_LEN;
  localparam logic [OW-1:0] RIGHT_ANGLE = OW'(90) << ANGLE_FRAC_BITS;

  logic [1:0] projection_plane;

  always_ff @(posedge clk) begin
    if (rst) begin
      projection_plane <= pvla_pkg::PLANE_XZ;
    end else if (cfg_write_enable) begin
      projection_plane <= cfg_write_data;
    end
  end

  // stage enables, back to front
  logic en1, en2, en3, en4, en5, enr;
  logic v1, v2, v3, v4, v5;
  logic [NST-1:0] cv;
  logic [NST-1:0] cen;

  // ---------------- stage 1: plane select and products
  logic signed [CB-1:0] u0, u1, w0, w1;
  logic                 zero_in;
  logic signed [PW-1:0] p_uw0, p_uw1, p_cr0, p_cr1;
  logic                 z1;

  always_comb begin
    case (projection_plane)
      pvla_pkg::PLANE_XY: begin
        u0 = first_x;  u1 = first_y;  w0 = second_x; w1 = second_y;
      end
      pvla_pkg::PLANE_YZ: begin
        u0 = first_y;  u1 = first_z;  w0 = second_y; w1 = second_z;
      end
      default: begin
        u0 = first_x;  u1 = first_z;  w0 = second_x; w1 = second_z;
      end
    endcase
    zero_in = ((u0 == '0) && (u1 == '0)) || ((w0 == '0) && (w1 == '0));
  end

  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      p_uw0 <= PW'(u0) * PW'(w0);
      p_uw1 <= PW'(u1) * PW'(w1);
      p_cr0 <= PW'(u0) * PW'(w1);
      p_cr1 <= PW'(u1) * PW'(w0);
      z1    <= zero_in;
    end
  end

  // ---------------- stage 2: |dot| and |cross|
  logic signed [PW:0] dot_s, crs_s;
  logic [PW:0]        dot_a, crs_a;
  logic [MW-1:0]      dm2, cm2;
  logic               z2;

  always_comb begin
    dot_s = {p_uw0[PW-1], p_uw0} + {p_uw1[PW-1], p_uw1};
    crs_s = {p_cr0[PW-1], p_cr0} - {p_cr1[PW-1], p_cr1};
    dot_a = dot_s[PW] ? -dot_s : dot_s;
    crs_a = crs_s[PW] ? -crs_s : crs_s;
  end

  assign en2 = !v2 || en3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      dm2 <= dot_a[MW-1:0];
      cm2 <= crs_a[MW-1:0];
      z2  <= z1;
    end
  end

  // ---------------- stage 3: larger magnitude
  logic [MW-1:0] dm3, cm3, top3;
  logic          z3;

  assign en3 = !v3 || en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      dm3  <= dm2;
      cm3  <= cm2;
      top3 <= (dm2 > cm2) ? dm2 : cm2;
      z3   <= z2;
    end
  end

  // ---------------- stage 4: leading-one position
  logic [POSW-1:0] pos_c;
  logic [MW-1:0]   dm4, cm4;
  logic [POSW-1:0] pos4;
  logic            z4;

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < MW; i++) begin
      if (top3[i]) begin
        pos_c = POSW'(i);
      end
    end
  end

  assign en4 = !v4 || en5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      dm4  <= dm3;
      cm4  <= cm3;
      pos4 <= pos_c;
      z4   <= z3;
    end
  end

  // ---------------- stage 5: normalize, leading one of the larger to NM
  logic [EXW-1:0] dm_ext, cm_ext;
  logic [NM:0]    xn5, yn5;
  logic           z5;

  always_comb begin
    dm_ext = {dm4, {NM{1'b0}}} >> pos4;
    cm_ext = {cm4, {NM{1'b0}}} >> pos4;
  end

  assign en5 = !v5 || cen[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      xn5 <= dm_ext[NM:0];
      yn5 <= cm_ext[NM:0];
      z5  <= z4;
    end
  end

  // ---------------- CORDIC vectoring stages
  logic signed [XW-1:0] cx [NST];
  logic signed [XW-1:0] cy [NST];
  logic signed [ZW-1:0] ca [NST];
  logic                 cz [NST];

  for (genvar k = 0; k < NST; k++) begin : g_cordic
    logic signed [XW-1:0] xi, yi, xs, ys;
    logic signed [ZW-1:0] ai, at;
    logic                 zi, vi;

    if (k == 0) begin : g_first
      assign xi = XW'(xn5);
      assign yi = XW'(yn5);
      assign ai = '0;
      assign zi = z5;
      assign vi = v5;
    end else begin : g_next
      assign xi = cx[k-1];
      assign yi = cy[k-1];
      assign ai = ca[k-1];
      assign zi = cz[k-1];
      assign vi = cv[k-1];
    end

    if (k == NST - 1) begin : g_last_en
      assign cen[k] = !cv[k] || enr;
    end else begin : g_mid_en
      assign cen[k] = !cv[k] || cen[k+1];
    end

    assign xs = xi >>> k;
    assign ys = yi >>> k;
    assign at = ZW'(pvla_pkg::ATAN_DEG[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k] <= 1'b0;
      end else if (cen[k]) begin
        cv[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (cen[k] && vi) begin
        cz[k] <= zi;
        if (yi > 0) begin
          cx[k] <= xi + ys;
          cy[k] <= yi - xs;
          ca[k] <= ai + at;
        end else if (yi < 0) begin
          cx[k] <= xi - ys;
          cy[k] <= yi + xs;
          ca[k] <= ai - at;
        end else begin
          cx[k] <= xi;
          cy[k] <= yi;
          ca[k] <= ai;
        end
      end
    end
  end

  // ---------------- round half up, clamp, output register
  logic signed [ZW-1:0] ang_r;
  logic [OW-1:0]        ang_out;

  always_comb begin
    ang_r = (ca[NST-1] + (ZW'(1) <<< (SH - 1))) >>> SH;
    if (cz[NST-1]) begin
      ang_out = RIGHT_ANGLE;
    end else if (ang_r < 0) begin
      ang_out = '0;
    end else if (ang_r > $signed(ZW'(RIGHT_ANGLE))) begin
      ang_out = RIGHT_ANGLE;
    end else begin
      ang_out = ang_r[OW-1:0];
    end
  end

  assign enr = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enr) begin
      out_valid <= cv[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (enr && cv[NST-1]) begin
      line_angle <= ang_out;
    end
  end

endmodule
